### rtl/upct_pkg.sv
package upct_pkg;

    // Table geometry and packet format.
    localparam int DEFAULT_SLOTS = 64;
    localparam int PAYLOAD_BYTES = 1024;
    localparam logic [10:0] HDR_BYTES = 11'd5;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROTOCOL_WORD = 2'd0,
        CFG_TIMEOUT_TICKS = 2'd1,
        CFG_SWEEP_INTERVAL = 2'd2,
        CFG_ACTIVE_SLOTS = 2'd3
    } t_cfg_reg;

    localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd5000;
    localparam logic [31:0] RST_SWEEP_INTERVAL = 32'd1000;
    localparam logic [6:0] RST_ACTIVE_SLOTS = 7'd64;

    // Input item modes and packet types.
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic [7:0] PKT_CONNECT = 8'd0;
    localparam logic [7:0] PKT_DISCONNECT = 8'd2;
    localparam logic [7:0] PKT_DATA = 8'd3;

    // Event kinds.
    localparam logic [1:0] KIND_CONNECT = 2'd0;
    localparam logic [1:0] KIND_DISCONNECT = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    typedef struct packed {
        logic mode;
        logic [31:0] src_host;
        logic [15:0] src_port;
        logic [31:0] header_word;
        logic [7:0] packet_type;
        logic [10:0] packet_length;
    } t_item;

    typedef struct packed {
        logic event_valid;
        logic [1:0] event_kind;
        logic send_ack;
        logic [5:0] client_index;
        logic [10:0] payload_length;
        logic [6:0] connected_count;
        logic last;
    } t_result;

    // One peer slot as held in the table memory.
    typedef struct packed {
        logic alive;
        logic [31:0] host;
        logic [15:0] port;
        logic [31:0] heard;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } t_state;

endpackage

### rtl/udp_peer_connection_table_unit.sv
// Channel        Ports                                  Transaction
// configuration  i_cfg_we, i_cfg_index, i_cfg_data      write when i_cfg_we is high
// item in        start, busy, i_item                    start high while busy is low
// result out     o_strobe, o_result                     one cycle per result, o_strobe high
//
// A packet or a sweeping tick scans the active slots through the table memory, one read
// per cycle, then passes through ST_WAIT and ST_FINISH before it turns idle again.
// A tick that does not sweep and a rejected packet do not scan; the block stays idle.
// After reset a clearing pass writes every slot, with busy high.
// Results come at most one per cycle and the receiver cannot stall them.
module udp_peer_connection_table_unit
    import upct_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic start,
    output logic busy,
    input t_item i_item,
    output logic o_strobe,
    output t_result o_result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers.
    logic [31:0] r_protocol;
    logic [31:0] r_timeout;
    logic [31:0] r_interval;
    logic [6:0] r_active;

    // Control and counters.
    t_state r_state;
    t_state n_state;
    logic [IW-1:0] r_idx;
    logic r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [6:0] r_live;
    logic [6:0] n_live;
    logic [31:0] r_now;
    logic [31:0] r_last_sweep;
    t_item r_item;

    // Scan findings.
    logic r_match_vld;
    logic [IW-1:0] r_match_idx;
    logic r_free_vld;
    logic [IW-1:0] r_free_idx;
    logic r_pend_vld;
    logic [IW-1:0] r_pend_idx;
    logic [6:0] r_pend_count;

    // Result register.
    logic r_strobe;
    logic n_strobe;
    t_result r_result;
    t_result n_result;

    // Table memory.
    logic ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry ram_wdata;
    t_entry rd_entry;

    logic [IW-1:0] last_idx;
    logic [31:0] now_inc;
    logic sweep_due;
    logic pkt_ok;
    logic go_scan;
    logic accept;
    logic hit;
    logic expire;
    logic [10:0] len_m5;
    logic [10:0] plen;
    t_entry new_entry;

    upct_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(rd_entry)
    );

    // Last slot searched or swept, from the active slot count clamped to 1..SLOTS.
    always_comb begin
        if (r_active == 7'd0) begin
            last_idx = '0;
        end else if (32'(r_active) > SLOTS) begin
            last_idx = IW'(SLOTS - 1);
        end else begin
            last_idx = IW'(r_active - 7'd1);
        end
    end

    // Decide at the start whether the item needs a scan.
    assign now_inc = r_now + 32'd1;
    assign sweep_due = (now_inc - r_last_sweep) > r_interval;
    assign pkt_ok = (i_item.packet_length >= HDR_BYTES)
                    && (i_item.header_word == r_protocol)
                    && ((i_item.packet_type == PKT_CONNECT)
                        || (i_item.packet_type == PKT_DISCONNECT)
                        || (i_item.packet_type == PKT_DATA));
    assign go_scan = (i_item.mode == MODE_TICK) ? sweep_due : pkt_ok;
    assign busy = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Checks on the entry that returned from memory this cycle.
    assign hit = rd_entry.alive && (rd_entry.host == r_item.src_host)
                 && (rd_entry.port == r_item.src_port);
    assign expire = rd_entry.alive && ((r_now - rd_entry.heard) > r_timeout);

    // Payload length, saturated.
    assign len_m5 = r_item.packet_length - HDR_BYTES;
    assign plen = (12'(len_m5) > 12'(PAYLOAD_BYTES)) ? 11'(PAYLOAD_BYTES) : len_m5;

    assign new_entry = '{alive: 1'b1, host: r_item.src_host, port: r_item.src_port,
                         heard: r_now};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == IW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start && go_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == last_idx) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    // Memory writes, result and live count.
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        n_strobe = 1'b0;
        n_result = '0;
        n_live = r_live;
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_SCAN, ST_WAIT: begin
                // An expired peer is dropped; the previous one found is released.
                if (r_rd_vld && (r_item.mode == MODE_TICK) && expire) begin
                    ram_we = 1'b1;
                    ram_waddr = r_rd_idx;
                    ram_wdata = rd_entry;
                    ram_wdata.alive = 1'b0;
                    n_live = r_live - 7'd1;
                    if (r_pend_vld) begin
                        n_strobe = 1'b1;
                        n_result.event_valid = 1'b1;
                        n_result.event_kind = KIND_DISCONNECT;
                        n_result.client_index = 6'(r_pend_idx);
                        n_result.connected_count = r_pend_count;
                    end
                end
            end
            ST_FINISH: begin
                n_result.last = 1'b1;
                if (r_item.mode == MODE_TICK) begin
                    if (r_pend_vld) begin
                        n_strobe = 1'b1;
                        n_result.event_valid = 1'b1;
                        n_result.event_kind = KIND_DISCONNECT;
                        n_result.client_index = 6'(r_pend_idx);
                        n_result.connected_count = r_pend_count;
                    end
                end else begin
                    ram_wdata = new_entry;
                    ram_waddr = r_match_idx;
                    n_result.client_index = 6'(r_match_idx);
                    case (r_item.packet_type)
                        PKT_CONNECT: begin
                            n_result.event_kind = KIND_CONNECT;
                            n_result.send_ack = 1'b1;
                            if (r_match_vld) begin
                                ram_we = 1'b1;
                                n_strobe = 1'b1;
                            end else if (r_free_vld) begin
                                ram_we = 1'b1;
                                ram_waddr = r_free_idx;
                                n_live = r_live + 7'd1;
                                n_strobe = 1'b1;
                                n_result.event_valid = 1'b1;
                                n_result.client_index = 6'(r_free_idx);
                            end
                        end
                        PKT_DISCONNECT: begin
                            ram_wdata.alive = 1'b0;
                            n_result.event_kind = KIND_DISCONNECT;
                            n_result.event_valid = 1'b1;
                            if (r_match_vld) begin
                                ram_we = 1'b1;
                                n_live = r_live - 7'd1;
                                n_strobe = 1'b1;
                            end
                        end
                        PKT_DATA: begin
                            n_result.event_kind = KIND_DATA;
                            n_result.event_valid = 1'b1;
                            n_result.payload_length = plen;
                            if (r_match_vld) begin
                                ram_we = 1'b1;
                                n_strobe = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
                n_result.connected_count = n_live;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx <= '0;
            r_rd_vld <= 1'b0;
            r_live <= '0;
            r_now <= '0;
            r_last_sweep <= '0;
            r_match_vld <= 1'b0;
            r_free_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_protocol <= '0;
            r_timeout <= RST_TIMEOUT_TICKS;
            r_interval <= RST_SWEEP_INTERVAL;
            r_active <= RST_ACTIVE_SLOTS;
        end else begin
            r_state <= n_state;
            r_live <= n_live;
            r_strobe <= n_strobe;
            r_rd_vld <= (r_state == ST_SCAN);

            // Scan address.
            if (r_state == ST_CLEAR || r_state == ST_SCAN) begin
                r_idx <= r_idx + IW'(1);
            end else begin
                r_idx <= '0;
            end

            // Item accepted: time moves on for a tick, findings are cleared.
            if (accept) begin
                r_match_vld <= 1'b0;
                r_free_vld <= 1'b0;
                r_pend_vld <= 1'b0;
                if (i_item.mode == MODE_TICK) begin
                    r_now <= now_inc;
                    if (sweep_due) begin
                        r_last_sweep <= now_inc;
                    end
                end
            end

            // Findings from the entry that returned this cycle.
            if (r_rd_vld) begin
                if (r_item.mode == MODE_TICK) begin
                    if (expire) begin
                        r_pend_vld <= 1'b1;
                    end
                end else begin
                    if (!r_match_vld && hit) begin
                        r_match_vld <= 1'b1;
                    end
                    if (!r_free_vld && !rd_entry.alive) begin
                        r_free_vld <= 1'b1;
                    end
                end
            end

            // Configuration writes.
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_PROTOCOL_WORD: r_protocol <= i_cfg_data;
                    CFG_TIMEOUT_TICKS: r_timeout <= i_cfg_data;
                    CFG_SWEEP_INTERVAL: r_interval <= i_cfg_data;
                    CFG_ACTIVE_SLOTS: r_active <= i_cfg_data[6:0];
                    default: r_active <= r_active;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        r_result <= n_result;
        if (accept) begin
            r_item <= i_item;
        end
        if (r_rd_vld) begin
            if (r_item.mode == MODE_TICK) begin
                if (expire) begin
                    r_pend_idx <= r_rd_idx;
                    r_pend_count <= r_live - 7'd1;
                end
            end else begin
                if (!r_match_vld && hit) begin
                    r_match_idx <= r_rd_idx;
                end
                if (!r_free_vld && !rd_entry.alive) begin
                    r_free_idx <= r_rd_idx;
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The final result of an item leaves as the block turns idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("final result while still busy");

    // The table is never written while idle.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("table write while idle");

    // Read data is examined only for reads issued by the scan.
    a_read_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == ST_SCAN))
        else $error("read data without a scan read");

    // A packet transaction ends in at most one result.
    a_packet_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_item.mode == MODE_PACKET)) |-> o_result.last)
        else $error("packet gave a result that is not the last");

    // The live count stays within the table.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SLOTS > 127) || (32'(r_live) <= SLOTS))
        else $error("live count above table size");

endmodule

### rtl/upct_ram.sv
module upct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input logic i_clk,
    input logic i_we,
    input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input logic [WIDTH-1:0] i_wdata,
    input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
